>>> design/mrps_pkg.sv
`default_nettype none
package mrps_pkg;

    // working width of the index arithmetic, which wraps modulo 2^64
    localparam int VAL_W = 64;
    // width of a subsystem dimension value
    localparam int DIM_W = 8;
    localparam int CFG_W = 32;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_SYSTEMS = 3'd0,
        REG_SYSTEM_DIMS = 3'd1,
        REG_NUM_PAIRS   = 3'd2,
        REG_PAIR_LIST   = 3'd3,
        REG_SWAP_POS_A  = 3'd4,
        REG_SWAP_POS_B  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic             valid;
        logic             bad;
        logic [VAL_W-1:0] idx;
    } item_t;

    typedef struct packed {
        logic             active;
        logic [VAL_W-1:0] wi;
        logic [VAL_W-1:0] wj;
        logic [DIM_W-1:0] dim_i;
        logic [DIM_W-1:0] dim_j;
        logic [7:0]       swap_a;
        logic [7:0]       swap_b;
        logic [VAL_W-1:0] c_ab;
        logic [VAL_W-1:0] c_ba;
    } pair_cfg_t;

endpackage
`default_nettype wire

>>> design/mrps_pair_unit.sv
`default_nettype none
module mrps_pair_unit
    import mrps_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      en,
    input  wire pair_cfg_t cfg,
    input  wire item_t     in_item,
    output item_t          out_item
);

    localparam int DIV_N  = VAL_W;
    localparam int MOD_K  = 8;
    localparam int MOD_N  = VAL_W / MOD_K;

    // long division of the index by both weights, one quotient bit a stage
    item_t            div_item_reg [DIV_N];
    logic [VAL_W-1:0] div_ri_reg   [DIV_N];
    logic [VAL_W-1:0] div_qi_reg   [DIV_N];
    logic [VAL_W-1:0] div_rj_reg   [DIV_N];
    logic [VAL_W-1:0] div_qj_reg   [DIV_N];

    // quotient modulo the dimension, eight quotient bits a stage
    item_t            mod_item_reg [MOD_N];
    logic [DIM_W-1:0] mod_ri_reg   [MOD_N];
    logic [DIM_W-1:0] mod_rj_reg   [MOD_N];
    logic [VAL_W-1:0] mod_qi_reg   [MOD_N];
    logic [VAL_W-1:0] mod_qj_reg   [MOD_N];

    item_t            prd_item_reg;
    logic [VAL_W-1:0] prd_pi_reg;
    logic [VAL_W-1:0] prd_pj_reg;
    logic             prd_ma_reg;
    logic             prd_mb_reg;

    item_t            fin_item_reg;

    function automatic logic [DIM_W-1:0] mod_step(input logic [DIM_W-1:0] r,
                                                  input logic b,
                                                  input logic [DIM_W-1:0] d);
        logic [DIM_W:0] rs;
        rs = {r, b};
        if (rs >= {1'b0, d}) begin
            rs = rs - {1'b0, d};
        end
        return rs[DIM_W-1:0];
    endfunction

    genvar s;
    generate
        for (s = 0; s < DIV_N; s++) begin : g_div
            item_t            it_prev;
            logic [VAL_W-1:0] ri_prev, qi_prev, rj_prev, qj_prev;
            logic [VAL_W:0]   rsi, rsj;
            logic             gei, gej;
            logic [VAL_W-1:0] qi_new, qj_new;
            if (s == 0) begin : g_first
                assign it_prev = in_item;
                assign ri_prev = '0;
                assign qi_prev = '0;
                assign rj_prev = '0;
                assign qj_prev = '0;
            end else begin : g_rest
                assign it_prev = div_item_reg[s-1];
                assign ri_prev = div_ri_reg[s-1];
                assign qi_prev = div_qi_reg[s-1];
                assign rj_prev = div_rj_reg[s-1];
                assign qj_prev = div_qj_reg[s-1];
            end
            assign rsi = {ri_prev, it_prev.idx[VAL_W-1-s]};
            assign rsj = {rj_prev, it_prev.idx[VAL_W-1-s]};
            assign gei = rsi >= {1'b0, cfg.wi};
            assign gej = rsj >= {1'b0, cfg.wj};
            always_comb begin
                qi_new = qi_prev;
                qj_new = qj_prev;
                qi_new[VAL_W-1-s] = gei;
                qj_new[VAL_W-1-s] = gej;
            end
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    div_item_reg[s].valid <= 1'b0;
                end else if (en) begin
                    div_item_reg[s].valid <= it_prev.valid;
                end
                if (en) begin
                    div_item_reg[s].bad <= it_prev.bad;
                    div_item_reg[s].idx <= it_prev.idx;
                    div_ri_reg[s] <= gei ? VAL_W'(rsi - {1'b0, cfg.wi}) : rsi[VAL_W-1:0];
                    div_rj_reg[s] <= gej ? VAL_W'(rsj - {1'b0, cfg.wj}) : rsj[VAL_W-1:0];
                    div_qi_reg[s] <= qi_new;
                    div_qj_reg[s] <= qj_new;
                end
            end
        end

        for (s = 0; s < MOD_N; s++) begin : g_mod
            item_t            it_prev;
            logic [DIM_W-1:0] ri_prev, rj_prev;
            logic [VAL_W-1:0] qi_prev, qj_prev;
            logic [DIM_W-1:0] ri_new, rj_new;
            if (s == 0) begin : g_first
                assign it_prev = div_item_reg[DIV_N-1];
                assign ri_prev = '0;
                assign rj_prev = '0;
                assign qi_prev = div_qi_reg[DIV_N-1];
                assign qj_prev = div_qj_reg[DIV_N-1];
            end else begin : g_rest
                assign it_prev = mod_item_reg[s-1];
                assign ri_prev = mod_ri_reg[s-1];
                assign rj_prev = mod_rj_reg[s-1];
                assign qi_prev = mod_qi_reg[s-1];
                assign qj_prev = mod_qj_reg[s-1];
            end
            always_comb begin
                ri_new = ri_prev;
                rj_new = rj_prev;
                for (int b = 0; b < MOD_K; b++) begin
                    ri_new = mod_step(ri_new, qi_prev[VAL_W-1-(s*MOD_K)-b], cfg.dim_i);
                    rj_new = mod_step(rj_new, qj_prev[VAL_W-1-(s*MOD_K)-b], cfg.dim_j);
                end
            end
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    mod_item_reg[s].valid <= 1'b0;
                end else if (en) begin
                    mod_item_reg[s].valid <= it_prev.valid;
                end
                if (en) begin
                    mod_item_reg[s].bad <= it_prev.bad;
                    mod_item_reg[s].idx <= it_prev.idx;
                    mod_ri_reg[s] <= ri_new;
                    mod_rj_reg[s] <= rj_new;
                    mod_qi_reg[s] <= qi_prev;
                    mod_qj_reg[s] <= qj_prev;
                end
            end
        end
    endgenerate

    // joint value of the two digits and the weight of each digit
    logic [2*DIM_W:0] joint;
    logic [DIM_W-1:0] dig_i, dig_j;
    assign dig_i = mod_ri_reg[MOD_N-1];
    assign dig_j = mod_rj_reg[MOD_N-1];
    assign joint = (2*DIM_W+1)'(dig_i * cfg.dim_j) + (2*DIM_W+1)'(dig_j);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prd_item_reg.valid <= 1'b0;
            fin_item_reg.valid <= 1'b0;
        end else if (en) begin
            prd_item_reg.valid <= mod_item_reg[MOD_N-1].valid;
            fin_item_reg.valid <= prd_item_reg.valid;
        end
        if (en) begin
            prd_item_reg.bad <= mod_item_reg[MOD_N-1].bad;
            prd_item_reg.idx <= mod_item_reg[MOD_N-1].idx;
            prd_pi_reg <= VAL_W'(cfg.wi * dig_i);
            prd_pj_reg <= VAL_W'(cfg.wj * dig_j);
            prd_ma_reg <= joint == (2*DIM_W+1)'(cfg.swap_a);
            prd_mb_reg <= joint == (2*DIM_W+1)'(cfg.swap_b);
            fin_item_reg.bad <= prd_item_reg.bad;
            if (cfg.active && !prd_item_reg.bad && (prd_ma_reg || prd_mb_reg)) begin
                fin_item_reg.idx <= prd_item_reg.idx - prd_pi_reg - prd_pj_reg
                                    + (prd_ma_reg ? cfg.c_ab : cfg.c_ba);
            end else begin
                fin_item_reg.idx <= prd_item_reg.idx;
            end
        end
    end

    assign out_item = fin_item_reg;

endmodule
`default_nettype wire

>>> design/mixed_radix_pair_swap_index_top.sv
// Mixed-radix pair swap index remapper.
// Input channel s_valid/s_ready carries one flat index a beat; the result
// channel m_valid/m_ready returns the remapped index and an error flag, one
// beat per input beat, in order.
// Registers are written on cfg_we with cfg_index and cfg_wdata; after each
// write, and after reset, a sequencer derives the weights and the per-pair
// swap offsets, holding s_ready low while it runs (the dimension chain, one
// system a cycle, then per pair two reads, and per swap direction an 8-bit
// division and two multiplies, one step a cycle).
// Throughput is one beat per cycle while the receiver takes results and the
// sequencer is idle. The pipeline is an input stage, then per pair a
// 64-stage long division of the index by both digit weights, 8 stages of
// digit extraction and 2 stages of recomposition.
// When the receiver stalls, the whole pipeline holds, with the last stage
// acting as the output register; nothing is lost or repeated.
// Reset is synchronous and active low; it clears the valid bits and loads
// the register defaults.
`default_nettype none
module mixed_radix_pair_swap_index_top
    import mrps_pkg::*;
#(
    parameter int MAX_SYSTEMS = 8,
    parameter int MAX_PAIRS   = 4,
    parameter int INDEX_BITS  = 16,
    parameter int DIM_BITS    = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [INDEX_BITS-1:0] s_flat_index,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [INDEX_BITS-1:0]      m_mapped_index,
    output logic                       m_bad_item,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_wdata
);

    localparam int KW = $clog2(MAX_SYSTEMS);
    localparam int PW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam logic [DIM_W-1:0] DIM_MASK = DIM_W'((9'd1 << DIM_BITS) - 9'd1);

    typedef enum logic [2:0] {
        S_IDLE, S_WTS, S_RDI, S_RDJ, S_DIV, S_MA, S_MB
    } seq_state_t;

    // configuration registers
    logic [3:0]  num_systems_reg;
    logic [31:0] system_dims_reg;
    logic [2:0]  num_pairs_reg;
    logic [23:0] pair_list_reg;
    logic [7:0]  swap_pos_a_reg;
    logic [7:0]  swap_pos_b_reg;

    // derived values
    seq_state_t       state_reg;
    logic [KW-1:0]    k_reg;
    logic [PW-1:0]    p_reg;
    logic             dir_reg;
    logic [2:0]       bit_reg;
    logic [DIM_W-1:0] dv_r_reg;
    logic [7:0]       dv_q_reg;
    logic [VAL_W-1:0] total_reg;
    logic [VAL_W-1:0] wi_tmp_reg;
    logic [VAL_W-1:0] wj_tmp_reg;
    logic [VAL_W-1:0] acc_reg;
    logic [VAL_W-1:0] wts_reg  [MAX_SYSTEMS];
    logic [VAL_W-1:0] wi_reg   [MAX_PAIRS];
    logic [VAL_W-1:0] wj_reg   [MAX_PAIRS];
    logic [VAL_W-1:0] c_ab_reg [MAX_PAIRS];
    logic [VAL_W-1:0] c_ba_reg [MAX_PAIRS];

    function automatic logic [DIM_W-1:0] dim_field(input logic [31:0] sd, input int k);
        logic [VAL_W-1:0] t;
        t = {32'b0, sd} >> (k * DIM_BITS);
        return t[DIM_W-1:0] & DIM_MASK;
    endfunction

    function automatic logic [2:0] pair_field(input logic [23:0] pl, input int k,
                                              input int sec);
        int sh;
        sh = 6 * k + 3 * sec;
        if (sh >= 24) begin
            return 3'd0;
        end
        return 3'(pl >> sh);
    endfunction

    logic [3:0] n_eff, np_eff;
    assign n_eff  = (num_systems_reg > 4'(MAX_SYSTEMS)) ? 4'(MAX_SYSTEMS) : num_systems_reg;
    assign np_eff = ({1'b0, num_pairs_reg} > 4'(MAX_PAIRS)) ? 4'(MAX_PAIRS)
                                                             : {1'b0, num_pairs_reg};

    // a pair in use that names a missing system spoils every beat
    logic pairs_bad;
    always_comb begin
        pairs_bad = 1'b0;
        for (int p = 0; p < MAX_PAIRS; p++) begin
            if (4'(p) < np_eff && ({1'b0, pair_field(pair_list_reg, p, 0)} >= n_eff ||
                                   {1'b0, pair_field(pair_list_reg, p, 1)} >= n_eff)) begin
                pairs_bad = 1'b1;
            end
        end
    end

    logic [2:0]       cur_i, cur_j;
    logic [DIM_W-1:0] cur_dim_j;
    logic [7:0]       cur_t;
    logic [DIM_W:0]   dv_rs;
    logic             dv_ge;
    assign cur_i     = pair_field(pair_list_reg, int'(p_reg), 0);
    assign cur_j     = pair_field(pair_list_reg, int'(p_reg), 1);
    assign cur_dim_j = dim_field(system_dims_reg, int'(cur_j));
    // direction 0 handles a joint value equal to position a, which becomes b
    assign cur_t     = dir_reg ? swap_pos_a_reg : swap_pos_b_reg;
    assign dv_rs     = {dv_r_reg, cur_t[bit_reg]};
    assign dv_ge     = dv_rs >= {1'b0, cur_dim_j};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_systems_reg <= 4'd1;
            system_dims_reg <= 32'h1111_1111;
            num_pairs_reg   <= 3'd0;
            pair_list_reg   <= 24'd0;
            swap_pos_a_reg  <= 8'd0;
            swap_pos_b_reg  <= 8'd0;
            state_reg       <= S_WTS;
            k_reg           <= KW'(MAX_SYSTEMS - 1);
            total_reg       <= VAL_W'(1);
            p_reg           <= '0;
            dir_reg         <= 1'b0;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_index))
                REG_NUM_SYSTEMS: num_systems_reg <= cfg_wdata[3:0];
                REG_SYSTEM_DIMS: system_dims_reg <= cfg_wdata;
                REG_NUM_PAIRS:   num_pairs_reg   <= cfg_wdata[2:0];
                REG_PAIR_LIST:   pair_list_reg   <= cfg_wdata[23:0];
                REG_SWAP_POS_A:  swap_pos_a_reg  <= cfg_wdata[7:0];
                REG_SWAP_POS_B:  swap_pos_b_reg  <= cfg_wdata[7:0];
                default: ;
            endcase
            // restart the derivation from the least significant system
            state_reg <= S_WTS;
            k_reg     <= KW'(MAX_SYSTEMS - 1);
            total_reg <= VAL_W'(1);
            p_reg     <= '0;
            dir_reg   <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: ;
                S_WTS: begin
                    if ({1'b0, k_reg} < n_eff) begin
                        wts_reg[k_reg] <= total_reg;
                        total_reg <= VAL_W'(total_reg * dim_field(system_dims_reg,
                                                                  int'(k_reg)));
                    end else begin
                        wts_reg[k_reg] <= VAL_W'(1);
                    end
                    if (k_reg == '0) begin
                        state_reg <= S_RDI;
                    end
                    k_reg <= k_reg - KW'(1);
                end
                S_RDI: begin
                    wi_tmp_reg <= wts_reg[cur_i[KW-1:0]];
                    state_reg  <= S_RDJ;
                end
                S_RDJ: begin
                    wj_tmp_reg <= wts_reg[cur_j[KW-1:0]];
                    wi_reg[p_reg] <= wi_tmp_reg;
                    dv_r_reg  <= '0;
                    dv_q_reg  <= '0;
                    bit_reg   <= 3'd7;
                    state_reg <= S_DIV;
                end
                S_DIV: begin
                    wj_reg[p_reg] <= wj_tmp_reg;
                    dv_r_reg <= dv_ge ? DIM_W'(dv_rs - {1'b0, cur_dim_j}) : dv_rs[DIM_W-1:0];
                    dv_q_reg[bit_reg] <= dv_ge;
                    bit_reg <= bit_reg - 3'd1;
                    if (bit_reg == 3'd0) begin
                        state_reg <= S_MA;
                    end
                end
                S_MA: begin
                    acc_reg   <= VAL_W'(wi_tmp_reg * dv_q_reg);
                    state_reg <= S_MB;
                end
                S_MB: begin
                    if (dir_reg) begin
                        c_ba_reg[p_reg] <= acc_reg + VAL_W'(wj_tmp_reg * dv_r_reg);
                    end else begin
                        c_ab_reg[p_reg] <= acc_reg + VAL_W'(wj_tmp_reg * dv_r_reg);
                    end
                    if (!dir_reg) begin
                        dir_reg   <= 1'b1;
                        dv_r_reg  <= '0;
                        dv_q_reg  <= '0;
                        bit_reg   <= 3'd7;
                        state_reg <= S_DIV;
                    end else begin
                        dir_reg <= 1'b0;
                        if (int'(p_reg) == MAX_PAIRS - 1) begin
                            state_reg <= S_IDLE;
                        end else begin
                            p_reg     <= p_reg + PW'(1);
                            state_reg <= S_RDI;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // advance the whole pipeline unless the output beat is stalled
    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv && (state_reg == S_IDLE);

    item_t st0_reg;
    logic [VAL_W-1:0] in_idx;
    assign in_idx = VAL_W'(s_flat_index);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st0_reg.valid <= 1'b0;
        end else if (adv) begin
            st0_reg.valid <= s_valid && s_ready;
        end
        if (adv) begin
            st0_reg.idx <= in_idx;
            st0_reg.bad <= (in_idx >= total_reg) || pairs_bad;
        end
    end

    // unit u applies pair MAX_PAIRS-1-u, so the last pair goes first
    item_t chain [MAX_PAIRS+1];
    assign chain[0] = st0_reg;

    genvar u;
    generate
        for (u = 0; u < MAX_PAIRS; u++) begin : g_unit
            localparam int P = MAX_PAIRS - 1 - u;
            pair_cfg_t pcfg;
            always_comb begin
                pcfg.active = 4'(P) < np_eff;
                pcfg.wi     = wi_reg[P];
                pcfg.wj     = wj_reg[P];
                pcfg.dim_i  = dim_field(system_dims_reg, int'(pair_field(pair_list_reg, P, 0)));
                pcfg.dim_j  = dim_field(system_dims_reg, int'(pair_field(pair_list_reg, P, 1)));
                pcfg.swap_a = swap_pos_a_reg;
                pcfg.swap_b = swap_pos_b_reg;
                pcfg.c_ab   = c_ab_reg[P];
                pcfg.c_ba   = c_ba_reg[P];
            end
            mrps_pair_unit u_pair (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .en       (adv),
                .cfg      (pcfg),
                .in_item  (chain[u]),
                .out_item (chain[u+1])
            );
        end
    endgenerate

    assign m_valid        = chain[MAX_PAIRS].valid;
    assign m_mapped_index = chain[MAX_PAIRS].idx[INDEX_BITS-1:0];
    assign m_bad_item     = chain[MAX_PAIRS].bad;

    // a configuration write always starts a new derivation pass
    a_cfg_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_ready)
        else $error("input taken right after a configuration write");

    // an accepted beat lands in the input stage
    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> st0_reg.valid)
        else $error("accepted beat lost at the input stage");

    // a stalled pipeline holds its input stage
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (st0_reg.valid && !adv) |=> (st0_reg.valid && $stable(st0_reg.idx)))
        else $error("input stage changed under a stall");

endmodule
`default_nettype wire
